// File: rtl/bomu8_pkg.sv
// Shared types and constants for the byte-order-mark sniffer and UTF-16 to UTF-8 transcoder.
package bomu8_pkg;

    localparam int QUEUE_DEPTH = 2;

    // Byte-order marks.
    localparam logic [7:0] BOM8_B0  = 8'hEF;
    localparam logic [7:0] BOM8_B1  = 8'hBB;
    localparam logic [7:0] BOM8_B2  = 8'hBF;
    localparam logic [7:0] BOM16_FE = 8'hFE;
    localparam logic [7:0] BOM16_FF = 8'hFF;

    // UTF-8 encoding limits and prefixes.
    localparam logic [15:0] UNIT_LIM1 = 16'h0080;
    localparam logic [15:0] UNIT_LIM2 = 16'h0800;
    localparam logic [7:0]  LEAD2     = 8'hC0;
    localparam logic [7:0]  LEAD3     = 8'hE0;
    localparam logic [7:0]  CONT      = 8'h80;
    localparam logic [7:0]  CONT_MASK = 8'h3F;

    // Reported encodings.
    localparam logic [1:0] ENC_UTF8 = 2'd0;
    localparam logic [1:0] ENC_BE   = 2'd1;
    localparam logic [1:0] ENC_LE   = 2'd2;

    localparam logic [1:0] BOM_LEN16 = 2'd2;
    localparam logic [1:0] BOM_LEN8  = 2'd3;

    typedef enum logic [3:0] {
        MODE_DETECT = 4'b0001,
        MODE_UTF8   = 4'b0010,
        MODE_BE     = 4'b0100,
        MODE_LE     = 4'b1000
    } mode_t;

    // One queued command: up to three result items from one input item.
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      count;
        logic            has;
        logic            last;
        logic [1:0]      enc;
        logic [1:0]      bom;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// File: rtl/bomu8_front.sv
// Front part: accepts input items, tracks mark detection and UTF-16 pairing, builds commands.
module bomu8_front
    import bomu8_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       cmd_valid,
    output cmd_t       cmd
);

    mode_t       mode_reg, mode_next;
    logic [7:0]  p0_reg, p0_next;
    logic [7:0]  p1_reg, p1_next;
    logic [1:0]  pcnt_reg, pcnt_next;
    logic [7:0]  half_reg, half_next;
    logic        halfv_reg, halfv_next;
    logic [1:0]  strip_reg, strip_next;
    logic [15:0] unit;
    logic [1:0]  n_res;

    assign unit = (mode_reg == MODE_LE) ? {in_byte, half_reg} : {half_reg, in_byte};

    always_comb
    begin
        mode_next  = mode_reg;
        p0_next    = p0_reg;
        p1_next    = p1_reg;
        pcnt_next  = pcnt_reg;
        half_next  = half_reg;
        halfv_next = halfv_reg;
        strip_next = strip_reg;
        cmd        = '0;
        n_res      = 2'd0;

        unique case (mode_reg)
            MODE_DETECT:
            begin
                priority if (pcnt_reg == 2'd0)
                begin
                    if (in_last)
                    begin
                        mode_next    = MODE_UTF8;
                        cmd.bytes[0] = in_byte;
                        n_res        = 2'd1;
                    end
                    else
                    begin
                        p0_next   = in_byte;
                        pcnt_next = 2'd1;
                    end
                end
                else if (pcnt_reg == 2'd1)
                begin
                    priority if (p0_reg == BOM16_FE && in_byte == BOM16_FF)
                    begin
                        mode_next  = MODE_BE;
                        strip_next = BOM_LEN16;
                        pcnt_next  = 2'd0;
                    end
                    else if (p0_reg == BOM16_FF && in_byte == BOM16_FE)
                    begin
                        mode_next  = MODE_LE;
                        strip_next = BOM_LEN16;
                        pcnt_next  = 2'd0;
                    end
                    else if (p0_reg == BOM8_B0 && in_byte == BOM8_B1 && !in_last)
                    begin
                        p1_next   = in_byte;
                        pcnt_next = 2'd2;
                    end
                    else
                    begin
                        mode_next    = MODE_UTF8;
                        pcnt_next    = 2'd0;
                        cmd.bytes[0] = p0_reg;
                        cmd.bytes[1] = in_byte;
                        n_res        = 2'd2;
                    end
                end
                else
                begin
                    // The two held bytes are the start of the UTF-8 mark.
                    pcnt_next = 2'd0;
                    mode_next = MODE_UTF8;
                    if (in_byte == BOM8_B2)
                    begin
                        strip_next = BOM_LEN8;
                    end
                    else
                    begin
                        cmd.bytes[0] = p0_reg;
                        cmd.bytes[1] = p1_reg;
                        cmd.bytes[2] = in_byte;
                        n_res        = 2'd3;
                    end
                end
            end
            MODE_UTF8:
            begin
                cmd.bytes[0] = in_byte;
                n_res        = 2'd1;
            end
            MODE_BE, MODE_LE:
            begin
                if (!halfv_reg)
                begin
                    half_next  = in_byte;
                    halfv_next = 1'b1;
                end
                else
                begin
                    halfv_next = 1'b0;
                    priority if (unit < UNIT_LIM1)
                    begin
                        cmd.bytes[0] = unit[7:0];
                        n_res        = 2'd1;
                    end
                    else if (unit < UNIT_LIM2)
                    begin
                        cmd.bytes[0] = LEAD2 | {3'b000, unit[10:6]};
                        cmd.bytes[1] = CONT | (unit[7:0] & CONT_MASK);
                        n_res        = 2'd2;
                    end
                    else
                    begin
                        cmd.bytes[0] = LEAD3 | {4'b0000, unit[15:12]};
                        cmd.bytes[1] = CONT | (unit[13:6] & CONT_MASK);
                        cmd.bytes[2] = CONT | (unit[7:0] & CONT_MASK);
                        n_res        = 2'd3;
                    end
                end
            end
            default:
            begin
                mode_next = MODE_DETECT;
            end
        endcase

        cmd.enc  = (mode_next == MODE_BE) ? ENC_BE :
                   (mode_next == MODE_LE) ? ENC_LE : ENC_UTF8;
        cmd.bom  = strip_next;
        cmd.has  = 1'b1;
        cmd.last = in_last;

        // A last item that yields no byte still sends an empty end marker.
        if (in_last && n_res == 2'd0)
        begin
            n_res   = 2'd1;
            cmd.has = 1'b0;
        end
        cmd.count = n_res;
        cmd_valid = (n_res != 2'd0);

        if (in_last)
        begin
            mode_next  = MODE_DETECT;
            pcnt_next  = 2'd0;
            halfv_next = 1'b0;
            strip_next = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_DETECT;
            pcnt_reg  <= 2'd0;
            halfv_reg <= 1'b0;
            strip_reg <= 2'd0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            pcnt_reg  <= pcnt_next;
            halfv_reg <= halfv_next;
            strip_reg <= strip_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p0_reg   <= p0_next;
            p1_reg   <= p1_next;
            half_reg <= half_next;
        end
    end

endmodule

// File: rtl/bomu8_queue.sv
// Short command queue between the front and back parts.
module bomu8_queue
    import bomu8_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr_en,
    input  cmd_t      wr_data,
    input  logic      rd_en,
    output cmd_t      rd_data,
    output q_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    cmd_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             do_wr, do_rd;

    assign status.full  = (cnt_reg == FULL_CNT);
    assign status.empty = (cnt_reg == '0);
    assign do_wr        = wr_en && !status.full;
    assign do_rd        = rd_en && !status.empty;
    assign rd_data      = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: rtl/bomu8_back.sv
// Back part: walks each queued command and sends its result items through an output register.
module bomu8_back
    import bomu8_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       head,
    input  logic       head_valid,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       has_byte,
    output logic       out_last,
    output logic [1:0] detected_encoding,
    output logic [1:0] bom_length
);

    logic [1:0] idx_reg;
    logic       out_valid_reg;
    logic [7:0] byte_reg;
    logic       has_reg, last_reg;
    logic [1:0] enc_reg, bom_reg;
    logic       load, is_final;
    logic [7:0] sel_byte;

    assign load     = head_valid && (!out_valid_reg || out_ready);
    assign is_final = (idx_reg == head.count - 2'd1);
    assign pop      = load && is_final;

    always_comb
    begin
        unique case (idx_reg)
            2'd0:    sel_byte = head.bytes[0];
            2'd1:    sel_byte = head.bytes[1];
            default: sel_byte = head.bytes[2];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                idx_reg       <= is_final ? 2'd0 : idx_reg + 2'd1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= sel_byte;
            has_reg  <= head.has;
            last_reg <= head.last && is_final;
            enc_reg  <= head.enc;
            bom_reg  <= head.bom;
        end
    end

    assign out_valid         = out_valid_reg;
    assign out_byte          = byte_reg;
    assign has_byte          = has_reg;
    assign out_last          = last_reg;
    assign detected_encoding = enc_reg;
    assign bom_length        = bom_reg;

endmodule

// File: rtl/bom_sniff_utf16_to_utf8.sv
// Top level of the byte-order-mark sniffer and UTF-16 to UTF-8 transcoder.
//
// Input channel: in_valid/in_ready with in_byte and in_last, one byte of the
// text stream per item; in_last marks the final byte of a stream.
// Output channel: out_valid/out_ready with out_byte, has_byte, out_last,
// detected_encoding and bom_length. A leading mark is stripped; without one the
// held bytes are replayed and the stream passes through as UTF-8. In UTF-16
// mode each byte pair gives one to three UTF-8 bytes. A last item that yields
// no byte gives one item with has_byte low and out_last high.
// An input byte that produces output is written into the command queue when it
// is accepted; its first result item is then loaded into the output register.
// The back end sends one result item per cycle while the receiver takes them,
// so throughput is set by the output port. The front end takes one byte per
// cycle while the command queue has room.
// Reset clears detection state and empties the queue and output register.
// When the receiver stalls, the output item holds, the queue fills, and then
// in_ready drops until a slot frees. After a last byte, detection restarts.
module bom_sniff_utf16_to_utf8
    import bomu8_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       has_byte,
    output logic       out_last,
    output logic [1:0] detected_encoding,
    output logic [1:0] bom_length
);

    logic      accept, cmd_valid, pop;
    cmd_t      cmd, head;
    q_status_t q_stat;

    assign in_ready = !q_stat.full;
    assign accept   = in_valid && in_ready;

    bomu8_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .cmd_valid (cmd_valid),
        .cmd       (cmd)
    );

    bomu8_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept && cmd_valid),
        .wr_data (cmd),
        .rd_en   (pop),
        .rd_data (head),
        .status  (q_stat)
    );

    bomu8_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .head              (head),
        .head_valid        (!q_stat.empty),
        .pop               (pop),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .out_byte          (out_byte),
        .has_byte          (has_byte),
        .out_last          (out_last),
        .detected_encoding (detected_encoding),
        .bom_length        (bom_length)
    );

    // An empty end marker always closes the stream.
    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_byte |-> out_last)
        else $error("empty item without last flag");

    // The queue cannot be full and empty at once.
    a_queue_status: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue reports full and empty");

    // A command is only popped when the queue holds one.
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("pop from empty queue");

    // Every queued command yields at least one result item.
    a_cmd_count: assert property (@(posedge clk) disable iff (!rst_n)
        !q_stat.empty |-> head.count != 2'd0)
        else $error("queued command with no result items");

endmodule
